### rtl/core/dsa_pkg.sv
// shared types, constants and helpers of the table-driven string acceptor
package dsa_pkg;

  localparam int STATES      = 64;
  localparam int SYMBOL_BITS = 8;

  localparam int STATE_W    = 6;
  localparam int SYM_W      = 8;
  localparam int STATE_BITS = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int SYM_COUNT  = 1 << SYMBOL_BITS;
  localparam int TBL_AW     = STATE_BITS + SYMBOL_BITS;
  localparam int TBL_DEPTH  = 1 << TBL_AW;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_ADD_TRANS = 2'd0,
    OP_ADD_SYM   = 2'd1,
    OP_FEED      = 2'd2,
    OP_FINISH    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] to_state;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               invalid_symbol;
    logic               no_transition;
    logic [STATE_W-1:0] end_state;
  } out_item_t;

  typedef struct packed {
    logic                  vld;
    logic [STATE_BITS-1:0] target;
  } entry_t;

  function automatic logic state_ok(input logic [STATE_W-1:0] s);
    return {1'b0, s} < (STATE_W + 1)'(STATES);
  endfunction

  function automatic logic sym_ok(input logic [SYM_W-1:0] sym);
    return (sym >> SYMBOL_BITS) == '0;
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [STATE_W-1:0] s,
                                                 input logic [SYM_W-1:0] sym);
    return {s[STATE_BITS-1:0], sym[SYMBOL_BITS-1:0]};
  endfunction

endpackage

### rtl/core/dsa_ram.sv
// generic single-write, single-read ram with registered read data
module dsa_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/dfa_string_acceptor_top.sv
// top level of the programmable table-driven string acceptor
//
// Usage: after reset the block clears its 16384-entry transition table and its 256-entry
// alphabet, one entry of each per cycle, and holds in_stall high until both are cleared
// (configuration writes are taken throughout). It then accepts one request per cycle:
// add transition, add alphabet symbol, feed symbol or finish string. Each request passes
// through an issue stage, which issues its table and alphabet reads, and a resolve stage,
// which resolves them, and the resolve stage loads a finish result into the output
// register. The next feed takes its table address straight from the state update of the
// feed ahead of it, and a transition or alphabet add that lands on an entry just read is
// forwarded, so back-to-back requests keep one per cycle. Only a finish stalls, and only
// while the previous result waits on out_stall. Write the start state and final mask
// registers while no request is in flight.
module dfa_string_acceptor_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dsa_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dsa_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dsa_pkg::*;

  logic [STATE_W-1:0] start_r;
  logic [STATES-1:0]  final_r;

  logic               clr_busy_r;
  logic [TBL_AW-1:0]  clr_cnt_r;

  logic               a_vld_r;
  in_item_t           a_r;
  logic               b_vld_r;
  in_item_t           b_r;
  logic [TBL_AW-1:0]  b_addr_r;

  logic [STATE_W-1:0]   cur_r, cur_nxt;
  logic                 dead_r, dead_nxt;
  logic                 inv_r, inv_nxt;

  logic               fwd_vld_r, fwd_vld_nxt;
  logic [TBL_AW-1:0]  fwd_addr_r;
  entry_t             fwd_data_r;

  logic                   al_fwd_vld_r;
  logic [SYMBOL_BITS-1:0] al_fwd_sym_r;
  logic                   al_we;
  logic                   al_rdata;
  logic                   al_bit;
  logic                   al_ram_we;
  logic [SYMBOL_BITS-1:0] al_waddr;
  logic                   al_ram_wdata;

  logic               out_vld_r;
  out_item_t          out_r, out_nxt;

  logic               in_acc;
  logic               b_done;
  logic               b_free;
  logic               a_adv;
  logic [TBL_AW-1:0]  a_addr;
  entry_t             ram_rdata;
  entry_t             ent;
  logic               ram_we;
  logic [TBL_AW-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic               tr_we;
  entry_t             tr_wdata;
  logic               sym_bad;
  logic               res_load;

  assign b_done   = b_vld_r && ((b_r.op != OP_FINISH) || !out_vld_r || !out_stall);
  assign b_free   = !b_vld_r || b_done;
  assign a_adv    = a_vld_r && b_free;
  assign in_stall = clr_busy_r || (a_vld_r && !b_free);
  assign in_acc   = in_valid && !in_stall;
  assign res_load = b_done && (b_r.op == OP_FINISH);

  assign ent = (fwd_vld_r && (fwd_addr_r == b_addr_r)) ? fwd_data_r : ram_rdata;
  assign al_bit = al_rdata ||
                  (al_fwd_vld_r && (al_fwd_sym_r == b_r.symbol[SYMBOL_BITS-1:0]));

  always_comb begin
    cur_nxt   = cur_r;
    dead_nxt  = dead_r;
    inv_nxt   = inv_r;
    al_we     = 1'b0;
    out_nxt   = out_r;
    tr_we     = 1'b0;
    tr_wdata  = '{vld: 1'b1, target: b_r.to_state[STATE_BITS-1:0]};
    sym_bad   = !sym_ok(b_r.symbol) || !al_bit;
    if (b_done) begin
      case (b_r.op)
        OP_ADD_TRANS: begin
          if (state_ok(b_r.from_state) && state_ok(b_r.to_state) && sym_ok(b_r.symbol) &&
              (!ent.vld || (b_r.to_state < STATE_W'(ent.target)))) begin
            tr_we = 1'b1;
          end
        end
        OP_ADD_SYM: begin
          if (sym_ok(b_r.symbol)) begin
            al_we = 1'b1;
          end
        end
        OP_FEED: begin
          if (sym_bad) begin
            inv_nxt = 1'b1;
          end else if (!(dead_r || inv_r)) begin
            if (!state_ok(cur_r) || !ent.vld) begin
              dead_nxt = 1'b1;
            end else begin
              cur_nxt = STATE_W'(ent.target);
            end
          end
        end
        OP_FINISH: begin
          out_nxt.accepted       = !dead_r && !inv_r && final_r[cur_r];
          out_nxt.invalid_symbol = inv_r;
          out_nxt.no_transition  = dead_r;
          out_nxt.end_state      = cur_r;
          cur_nxt                = start_r;
          dead_nxt               = 1'b0;
          inv_nxt                = 1'b0;
        end
        default: begin
          cur_nxt = cur_r;
        end
      endcase
    end
  end

  // the read for the request in the issue slot sees the state after the one resolving
  assign a_addr = (a_r.op == OP_ADD_TRANS) ? tbl_addr(a_r.from_state, a_r.symbol)
                                           : tbl_addr(cur_nxt, a_r.symbol);

  assign ram_we      = clr_busy_r || tr_we;
  assign ram_waddr   = clr_busy_r ? clr_cnt_r : b_addr_r;
  assign ram_wdata   = clr_busy_r ? entry_t'('0) : tr_wdata;
  assign fwd_vld_nxt = tr_we && !clr_busy_r;

  dsa_ram #(
    .W     ($bits(entry_t)),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (a_addr),
    .rdata (ram_rdata)
  );

  assign al_ram_we    = clr_busy_r || al_we;
  assign al_waddr     = clr_busy_r ? clr_cnt_r[SYMBOL_BITS-1:0] : b_r.symbol[SYMBOL_BITS-1:0];
  assign al_ram_wdata = !clr_busy_r;

  dsa_ram #(
    .W     (1),
    .DEPTH (SYM_COUNT)
  ) u_alpha (
    .clk   (clk),
    .we    (al_ram_we),
    .waddr (al_waddr),
    .wdata (al_ram_wdata),
    .raddr (a_r.symbol[SYMBOL_BITS-1:0]),
    .rdata (al_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r      <= '0;
      final_r      <= '0;
      clr_busy_r   <= 1'b1;
      clr_cnt_r    <= '0;
      a_vld_r      <= 1'b0;
      b_vld_r      <= 1'b0;
      cur_r        <= '0;
      dead_r       <= 1'b0;
      inv_r        <= 1'b0;
      fwd_vld_r    <= 1'b0;
      al_fwd_vld_r <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_INIT_STATE: start_r <= cfg_wdata[STATE_W-1:0];
          CFG_FINAL_MASK: final_r <= cfg_wdata[STATES-1:0];
          default:        start_r <= start_r;
        endcase
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_acc) begin
        a_vld_r <= 1'b1;
      end else if (a_adv) begin
        a_vld_r <= 1'b0;
      end
      if (a_adv) begin
        b_vld_r <= 1'b1;
      end else if (b_done) begin
        b_vld_r <= 1'b0;
      end
      cur_r        <= cur_nxt;
      dead_r       <= dead_nxt;
      inv_r        <= inv_nxt;
      fwd_vld_r    <= fwd_vld_nxt;
      al_fwd_vld_r <= al_we;
      if (res_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r <= in_data;
    end
    if (a_adv) begin
      b_r      <= a_r;
      b_addr_r <= a_addr;
    end
    if (fwd_vld_nxt) begin
      fwd_addr_r <= b_addr_r;
      fwd_data_r <= tr_wdata;
    end
    if (al_we) begin
      al_fwd_sym_r <= b_r.symbol[SYMBOL_BITS-1:0];
    end
    if (res_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> clr_busy_r)
    else $error("table clear not started after reset");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !a_vld_r && !b_vld_r && !tr_we)
    else $error("request in flight during table clear");

  a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_vld_r && (out_r.end_state == $past(cur_r)))
    else $error("finish did not load the result register");

  a_accept_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.accepted |-> !out_r.invalid_symbol && !out_r.no_transition)
    else $error("accepted string carries an error flag");

  a_issue_moves: assert property (@(posedge clk) disable iff (!rst_n)
    a_adv |=> b_vld_r && (b_addr_r == $past(a_addr)))
    else $error("issued request lost between stages");

endmodule

### sim/acceptor_checker.sv
// checker for the string acceptor: tracks the automaton, predicts each verdict and compares
module acceptor_checker
  import dsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    errors
);

  // msb of an entry marks it present, the rest is the target state
  logic [STATE_W:0]     trans_tbl [TBL_DEPTH];
  logic [SYM_COUNT-1:0] alphabet;
  logic [STATE_W-1:0]   cur_state;
  logic [STATE_W-1:0]   start_reg;
  logic [63:0]          final_bits;
  logic                 dead;
  logic                 bad_sym;
  out_item_t            verdicts_due [$];
  int                   err_count = 0;

  assign errors = err_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] acceptor mismatch: %s", $time, what);
    err_count++;
  endtask

  task automatic apply_request(input in_item_t r);
    int               idx;
    logic [STATE_W:0] ent;
    out_item_t        v;
    case (r.op)
      OP_ADD_TRANS: begin
        if (int'(r.from_state) < STATES && int'(r.to_state) < STATES &&
            int'(r.symbol) < SYM_COUNT) begin
          idx = int'(r.from_state) * SYM_COUNT + int'(r.symbol);
          ent = trans_tbl[idx];
          if (!ent[STATE_W] || r.to_state < ent[STATE_W-1:0])
            trans_tbl[idx] = {1'b1, r.to_state};
        end
      end
      OP_ADD_SYM: begin
        if (int'(r.symbol) < SYM_COUNT)
          alphabet[r.symbol] = 1'b1;
      end
      OP_FEED: begin
        if (int'(r.symbol) >= SYM_COUNT || !alphabet[r.symbol]) begin
          bad_sym = 1'b1;
        end else if (!dead && !bad_sym) begin
          if (int'(cur_state) >= STATES) begin
            dead = 1'b1;
          end else begin
            ent = trans_tbl[int'(cur_state) * SYM_COUNT + int'(r.symbol)];
            if (ent[STATE_W])
              cur_state = ent[STATE_W-1:0];
            else
              dead = 1'b1;
          end
        end
      end
      default: begin
        v.accepted       = !dead && !bad_sym && final_bits[cur_state];
        v.invalid_symbol = bad_sym;
        v.no_transition  = dead;
        v.end_state      = cur_state;
        verdicts_due.insert(verdicts_due.size(), v);
        cur_state = start_reg;
        dead      = 1'b0;
        bad_sym   = 1'b0;
      end
    endcase
  endtask

  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch($sformatf("result with none expected: %p", got));
    end else begin
      want = verdicts_due.pop_front();
      if (got.accepted !== want.accepted)
        report_mismatch($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
      if (got.invalid_symbol !== want.invalid_symbol)
        report_mismatch($sformatf("invalid_symbol %b, expected %b",
                                  got.invalid_symbol, want.invalid_symbol));
      if (got.no_transition !== want.no_transition)
        report_mismatch($sformatf("no_transition %b, expected %b",
                                  got.no_transition, want.no_transition));
      if (got.end_state !== want.end_state)
        report_mismatch($sformatf("end_state %0d, expected %0d", got.end_state, want.end_state));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (trans_tbl[i]) trans_tbl[i] = '0;
      alphabet   = '0;
      start_reg  = '0;
      final_bits = '0;
      cur_state  = '0;
      dead       = 1'b0;
      bad_sym    = 1'b0;
      verdicts_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_INIT_STATE)
          start_reg = cfg_wdata[STATE_W-1:0];
        else if (cfg_idx == CFG_FINAL_MASK)
          final_bits = cfg_wdata;
      end
      if (out_valid && !out_stall)
        check_verdict(out_data);
      if (in_valid && !in_stall)
        apply_request(in_data);
    end
    pending <= verdicts_due.size();
  end

endmodule

### sim/tb_dfa_string_acceptor_top.sv
// testbench top for the string acceptor: directed and random requests, idle phases, verdict
module tb_dfa_string_acceptor_top;
  import dsa_pkg::*;

  localparam int ITEM_TARGET = 800;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    pending;
  int                    errors;
  idle_t                 idle_mode = IDLE_NONE;
  int                    cycle_count = 0;
  int                    items_sent  = 0;

  dfa_string_acceptor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  acceptor_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_dfa_string_acceptor_top: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_stall <= ($urandom_range(99) < 76);
      IDLE_BOTH:     out_stall <= ($urandom_range(99) < 26);
      default:       out_stall <= 1'b0;
    endcase
  end

  function automatic in_item_t req(op_t op, int from, int sym, int to);
    in_item_t r;
    r.op         = op;
    r.from_state = STATE_W'(from);
    r.symbol     = SYM_W'(sym);
    r.to_state   = STATE_W'(to);
    return r;
  endfunction

  task automatic send_req(input in_item_t r);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 76 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic feed(input int sym);
    send_req(req(OP_FEED, $urandom_range(63), sym, $urandom_range(63)));
  endtask

  task automatic finish_string();
    send_req(req(OP_FINISH, $urandom_range(63), $urandom_range(255), $urandom_range(63)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // quiet the input, let every verdict come back, then allow the pipeline to empty
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int                base;
    int                len;
    int                phase;
    int                sym;
    logic [SYM_W-1:0]  sym0;
    logic [SYM_W-1:0]  stride;
    logic [SYM_W-1:0]  focus [8];
    logic [63:0]       mask;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_INIT_STATE, CFG_DATA_W'(0));
    write_reg(CFG_FINAL_MASK, 64'h8000_0000_0000_0021);
    send_req(req(OP_ADD_SYM, 0, 8'h00, 0));
    send_req(req(OP_ADD_SYM, 63, 8'hFF, 63));
    send_req(req(OP_ADD_SYM, 0, 8'h55, 0));
    send_req(req(OP_ADD_TRANS, 0, 8'h00, 63));
    // lower target wins, higher one is dropped
    send_req(req(OP_ADD_TRANS, 0, 8'h00, 5));
    send_req(req(OP_ADD_TRANS, 0, 8'h00, 40));
    send_req(req(OP_ADD_TRANS, 5, 8'hFF, 63));
    send_req(req(OP_ADD_TRANS, 63, 8'h55, 0));
    finish_string();
    feed(8'h00);
    feed(8'hFF);
    feed(8'h55);
    feed(8'h00);
    finish_string();
    // dead string stops moving
    feed(8'hFF);
    feed(8'h00);
    finish_string();
    // symbol outside the alphabet
    feed(8'hAA);
    feed(8'h00);
    finish_string();
    // dead first, then a bad symbol
    feed(8'h00);
    feed(8'h00);
    feed(8'hAA);
    finish_string();
    // new start state only applies after the next finish
    feed(8'h00);
    drain();
    write_reg(CFG_INIT_STATE, CFG_DATA_W'(63));
    finish_string();
    finish_string();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      idle_mode = idle_t'(phase % 4);
      base = (phase % 5 == 0) ? 0 : (phase % 5 == 1) ? 56 : $urandom_range(56);
      mask = {$urandom, $urandom};
      if (phase % 6 == 0)
        mask = '1;
      else if (phase % 6 == 3)
        mask = '0;
      write_reg(CFG_FINAL_MASK, mask);
      write_reg(CFG_INIT_STATE,
                CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(63)
                                                     : base + $urandom_range(7)));

      sym0   = SYM_W'($urandom_range(255));
      stride = SYM_W'($urandom_range(255) | 1);
      foreach (focus[k]) focus[k] = sym0 + SYM_W'(k) * stride;

      foreach (focus[k])
        if ($urandom_range(99) < 85)
          send_req(req(OP_ADD_SYM, $urandom_range(63), focus[k], $urandom_range(63)));
      for (int s = 0; s < 8; s++)
        foreach (focus[k])
          if ($urandom_range(99) < 55)
            send_req(req(OP_ADD_TRANS, base + s, focus[k], base + $urandom_range(7)));

      repeat (12) begin
        if ($urandom_range(9) == 0)
          send_req(req(op_t'($urandom_range(3)), $urandom_range(63), $urandom_range(255),
                       $urandom_range(63)));
        len = $urandom_range(8);
        repeat (len) begin
          sym = ($urandom_range(99) < 90) ? focus[$urandom_range(7)] : $urandom_range(255);
          feed(sym);
        end
        finish_string();
      end
      phase++;
    end
    drain();

    if (errors == 0)
      $display("tb_dfa_string_acceptor_top: clean");
    else
      $display("tb_dfa_string_acceptor_top: errors");
    $finish;
  end

endmodule
